/* sv/waveform_shape_generator_core_defines.svh */
// Assertion macros used by the core checker.
`ifndef WAVEFORM_SHAPE_GENERATOR_CORE_DEFINES_SVH
`define WAVEFORM_SHAPE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define WSG_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define WSG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/wsg_pkg.sv */
`timescale 1ns / 1ps
package wsg_pkg;

   // Field widths
   localparam int PHASE_BITS = 16;
   localparam int AMP_W      = 15;
   localparam int SAMPLE_W   = 16;
   localparam int UNIT_W     = 17;   // Q1.15 unit value, +1 and -1 both representable
   localparam int SHAPE_W    = 3;
   localparam int DUTY_W     = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_WAVE_SHAPE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_DUTY = 1'd1;

   localparam logic [SHAPE_W-1:0] SHAPE_RESET = 3'd0;
   localparam logic [DUTY_W-1:0]  DUTY_RESET  = 16'd58982;

   // Shape codes
   localparam logic [SHAPE_W-1:0] SHAPE_SINE     = 3'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE = 3'd1;
   localparam logic [SHAPE_W-1:0] SHAPE_SAW      = 3'd2;
   localparam logic [SHAPE_W-1:0] SHAPE_SQUARE   = 3'd3;
   localparam logic [SHAPE_W-1:0] SHAPE_PULSE    = 3'd4;

   // Quarter-wave sine table
   localparam int SINE_TABLE_ENTRIES = 256;
   localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);
   localparam int SINE_W             = 16;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};

   typedef logic [SINE_W-1:0] sine_rom_type [SINE_TABLE_ENTRIES];

   typedef struct packed {
      logic [SHAPE_W-1:0] shape;
      logic [DUTY_W-1:0]  duty;
   } cfg_type;

   typedef struct packed {
      logic                     known;
      logic signed [UNIT_W-1:0] x;
   } unit_type;

   // sin(pi/2 * k / N) as a Q30 Taylor series to x^17, rounded half up to Q15
   function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] k);
      logic [63:0]        theta;
      logic [63:0]        sq;
      logic [63:0]        term;
      logic signed [63:0] sum;
      theta = (HALF_PI_Q30 * k) / SINE_TABLE_ENTRIES;
      sq    = (theta * theta) >> 30;
      term  = theta;
      sum   = signed'(theta);
      for (int n = 0; n < 8; n++) begin
         term = ((term * sq) >> 30) / TAYLOR_DIV[n];
         if (n[0] == 1'b0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32768) begin
         sum = 64'sd32768;
      end
      return sum[SINE_W-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int k = 0; k < SINE_TABLE_ENTRIES; k++) begin
         rom[k] = sine_entry(64'(k));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();
   localparam logic [SINE_W-1:0] SINE_TOP = sine_entry(64'(SINE_TABLE_ENTRIES));

endpackage

/* sv/wsg_channels.sv */
`timescale 1ns / 1ps
interface wsg_req_if import wsg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PHASE_BITS-1:0] phase;
   logic [AMP_W-1:0]      amplitude;

   modport source (output valid, output phase, output amplitude, input ready);
   modport sink   (input valid, input phase, input amplitude, output ready);
endinterface

interface wsg_rsp_if import wsg_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

/* sv/wsg_shape.sv */
`timescale 1ns / 1ps
module wsg_shape import wsg_pkg::*; (
   input  logic [PHASE_BITS-1:0] phase,
   input  cfg_type               cfg,
   output unit_type              unit
);

   localparam logic [31:0] QUARTER    = 32'h4000_0000;
   localparam logic [31:0] HALF       = 32'h8000_0000;
   localparam logic [31:0] THREE_QTR  = 32'hC000_0000;
   localparam logic signed [UNIT_W-1:0] POS_ONE = UNIT_W'(2**(UNIT_W-2));
   localparam logic signed [UNIT_W-1:0] NEG_ONE = -POS_ONE;
   localparam logic signed [UNIT_W+1:0] ONE_WIDE = (UNIT_W+2)'(2**(UNIT_W-2));
   localparam int PROD_W = 30 + SINE_IDX_W + 1;

   logic [31:0]                 p;
   logic [PROD_W-1:0]           idx_prod;
   logic [SINE_IDX_W-1:0]       idx;
   logic [SINE_IDX_W-1:0]       mirror_idx;
   logic [SINE_W-1:0]           t_fwd;
   logic [SINE_W-1:0]           t_rev;
   logic [SINE_W-1:0]           t_sel;
   logic signed [UNIT_W-1:0]    sine_x;
   logic [31:0]                 tri_dist;
   logic signed [UNIT_W+1:0]    tri_fall;
   logic signed [UNIT_W-1:0]    tri_x;
   logic signed [UNIT_W-1:0]    saw_x;

   assign p = 32'(phase) << (32 - PHASE_BITS);

   // Sine: quadrant from the top two bits, index scaled into the quarter table
   assign idx_prod   = PROD_W'(p[29:0]) * PROD_W'(SINE_TABLE_ENTRIES);
   assign idx        = idx_prod[30 +: SINE_IDX_W];
   assign mirror_idx = SINE_IDX_W'((SINE_IDX_W+1)'(SINE_TABLE_ENTRIES)
                                   - (SINE_IDX_W+1)'(idx));
   assign t_fwd      = SINE_ROM[idx];
   assign t_rev      = (idx == '0) ? SINE_TOP : SINE_ROM[mirror_idx];
   assign t_sel      = p[30] ? t_rev : t_fwd;
   assign sine_x     = p[31] ? -signed'(UNIT_W'(t_sel)) : signed'(UNIT_W'(t_sel));

   // Triangle: rising ramp in the first quarter, folded distance from 0.75 after
   assign tri_dist = (p >= THREE_QTR) ? (p - THREE_QTR) : (THREE_QTR - p);
   assign tri_fall = signed'((UNIT_W+2)'(tri_dist[31:15])) - ONE_WIDE;
   assign tri_x    = (p < QUARTER) ? signed'(UNIT_W'(p[31:15])) : tri_fall[UNIT_W-1:0];

   // Saw: the top half of the phase read as two's complement
   assign saw_x = UNIT_W'(signed'(p[31:16]));

   always_comb begin
      unit.known = 1'b1;
      unit.x     = '0;
      case (cfg.shape)
         SHAPE_SINE:     unit.x = sine_x;
         SHAPE_TRIANGLE: unit.x = tri_x;
         SHAPE_SAW:      unit.x = saw_x;
         SHAPE_SQUARE:   unit.x = (p < HALF) ? POS_ONE : NEG_ONE;
         SHAPE_PULSE:    unit.x = (p < {cfg.duty, 16'h0000}) ? POS_ONE : NEG_ONE;
         default:        unit.known = 1'b0;
      endcase
   end

endmodule

/* sv/wsg_scale.sv */
`timescale 1ns / 1ps
module wsg_scale import wsg_pkg::*; (
   input  unit_type                   unit,
   input  logic [AMP_W-1:0]           amplitude,
   output logic signed [SAMPLE_W-1:0] sample
);

   localparam int PROD_W = AMP_W + UNIT_W;
   localparam logic signed [UNIT_W:0] SAT_HI = (UNIT_W+1)'(2**(SAMPLE_W-1) - 1);
   localparam logic signed [UNIT_W:0] SAT_LO = -SAT_HI - (UNIT_W+1)'(1);

   logic [UNIT_W-1:0]        mag_x;
   logic [PROD_W-1:0]        prod;
   logic [UNIT_W-1:0]        mag;
   logic signed [UNIT_W:0]   signed_mag;

   assign mag_x = unit.x[UNIT_W-1] ? UNIT_W'(-unit.x) : UNIT_W'(unit.x);
   assign prod  = PROD_W'(amplitude) * PROD_W'(mag_x);
   // truncate toward zero: scale the magnitude, then restore the sign
   assign mag   = prod[15 +: UNIT_W];
   assign signed_mag = unit.x[UNIT_W-1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});

   always_comb begin
      if (!unit.known) begin
         sample = '0;
      end else if (signed_mag > SAT_HI) begin
         sample = SAT_HI[SAMPLE_W-1:0];
      end else if (signed_mag < SAT_LO) begin
         sample = SAT_LO[SAMPLE_W-1:0];
      end else begin
         sample = signed_mag[SAMPLE_W-1:0];
      end
   end

endmodule

/* sv/waveform_shape_generator_core.sv */
`timescale 1ns / 1ps
// Waveform shape generator: each request transfer carries a Q0.16 phase and an
// amplitude; each response transfer returns one signed 16-bit sample of the
// selected shape (sine, triangle, saw, square, pulse) scaled by the amplitude,
// truncated toward zero and saturated. The path is three register stages deep
// (input register, unit-value register, output register); each sample is
// offered from the output register and held there until its response transfer.
// Throughput is one item per cycle; the input is held off only while every
// stage is full and the output sample has not been taken. The shape and pulse
// duty registers must be written only while the pipeline is empty. Shape
// codes 5 to 7 give a sample of zero.
module waveform_shape_generator_core import wsg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   wsg_req_if.sink               req_chan,
   wsg_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // Configuration registers
   logic [SHAPE_W-1:0] shape_ff;
   logic [DUTY_W-1:0]  duty_ff;
   cfg_type            cfg;

   // Stage 1: input register
   logic                  in_valid_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [AMP_W-1:0]      amp_in_ff;

   // Stage 2: unit value register
   logic             x_valid_ff;
   unit_type         unit_in;
   unit_type         unit_ff;
   logic [AMP_W-1:0] amp_x_ff;

   // Stage 3: output register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic signed [SAMPLE_W-1:0] sample_ff;

   logic out_adv;
   logic x_adv;
   logic in_adv;

   // Register writes; unknown indexes fall through untouched
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_ff <= SHAPE_RESET;
         duty_ff  <= DUTY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WAVE_SHAPE: shape_ff <= csr_wr_data[SHAPE_W-1:0];
            CSR_PULSE_DUTY: duty_ff  <= csr_wr_data[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.shape = shape_ff;
   assign cfg.duty  = duty_ff;

   // A stage advances when it is empty or the stage after it advances
   assign out_adv = !rsp_valid_ff || rsp_chan.ready;
   assign x_adv   = !x_valid_ff || out_adv;
   assign in_adv  = !in_valid_ff || x_adv;

   assign req_chan.ready = in_adv;

   // Stage 1: capture the request on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_adv) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && req_chan.valid) begin
         phase_ff  <= req_chan.phase;
         amp_in_ff <= req_chan.amplitude;
      end
   end

   // Phase to unit value
   wsg_shape u_shape (
      .phase (phase_ff),
      .cfg   (cfg),
      .unit  (unit_in)
   );

   // Stage 2: hold the unit value and carry the amplitude alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else if (x_adv) begin
         x_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (x_adv && in_valid_ff) begin
         unit_ff  <= unit_in;
         amp_x_ff <= amp_in_ff;
      end
   end

   // Amplitude scaling and saturation
   wsg_scale u_scale (
      .unit      (unit_ff),
      .amplitude (amp_x_ff),
      .sample    (sample_in)
   );

   // Stage 3: output register; hold the sample until the response transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= x_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv && x_valid_ff) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.sample = sample_ff;

endmodule

/* sv/wsg_core_checker.sv */
`timescale 1ns / 1ps
`include "waveform_shape_generator_core_defines.svh"
module wsg_core_checker import wsg_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample
);

   // A pending sample stays offered until taken
   `WSG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped before transfer")

   // A stalled sample keeps its value
   `WSG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_sample), "stalled rsp sample changed")

   // Reset empties the pipeline
   `WSG_ASSERT_SAME(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid, "rsp valid right after reset")

   // The input is only held off while the output holds an untaken sample
   `WSG_ASSERT_SAME(a_no_idle_stall, clock, reset, !rsp_valid || rsp_ready, req_ready, "req stalled while output free")

   // Ready is never unknown at a request transfer
   `WSG_ASSERT_SAME(a_req_known, clock, reset, req_valid && req_ready, !$isunknown(req_ready), "req ready unknown at transfer")

endmodule

bind waveform_shape_generator_core wsg_core_checker u_wsg_core_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.sample)
);
